### rtl/core/slotted_page_slot_manager_core_defines.svh
// Assertion helpers shared by the core modules.
`ifndef SLOTTED_PAGE_SLOT_MANAGER_CORE_DEFINES_SVH
`define SLOTTED_PAGE_SLOT_MANAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SPSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spsm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPSM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spsm assertion failed");

`endif

### rtl/core/spsm_pkg.sv
`default_nettype none
package spsm_pkg;

    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_SLOTS_DEF = 512;
    localparam int HEADER_BYTES  = 10;
    localparam int SLOT_BYTES    = 6;
    localparam int PAD_MASK      = 7;

    localparam int MODE_W    = 2;
    localparam int SLOT_ID_W = 9;
    localparam int TSZ_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int OFS_W     = 13;
    localparam int SIZE_W    = 13;
    localparam int FP_W      = $clog2(PAGE_BYTES + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_GET    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_UPDATE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_INVALID_SLOT = 2'd2,
        ST_SLOT_DELETED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RELOC
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic reloc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic reloc_needed;
    } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/spsm_ram.sv
`default_nettype none
module spsm_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/spsm_ctrl.sv
`default_nettype none
`include "slotted_page_slot_manager_core_defines.svh"
module spsm_ctrl
    import spsm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t dp_status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_status.reloc_needed) begin
                    state_next = S_RELOC;
                end else if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_RELOC: begin
                if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.reloc   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // take no item while reset is held
                s_ready     = aresetn;
                cmd.capture = s_valid && aresetn;
            end
            S_EXEC: begin
                // a relocating update only marks the old slot here, no result yet
                cmd.exec = dp_status.reloc_needed || dp_status.out_free;
            end
            S_RELOC: begin
                cmd.reloc = dp_status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    `SPSM_ASSERT_NXT(a_capture_to_exec, aclk, aresetn, cmd.capture, state_reg == S_EXEC)
    `SPSM_ASSERT_IMP(a_reloc_after_exec, aclk, aresetn, state_reg == S_RELOC,
                     $past(state_reg) == S_EXEC || $past(state_reg) == S_RELOC)

endmodule
`default_nettype wire

### rtl/core/spsm_dp.sv
`default_nettype none
`include "slotted_page_slot_manager_core_defines.svh"
module spsm_dp
    import spsm_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [MODE_W-1:0]    s_mode,
    input  wire logic [SLOT_ID_W-1:0] s_slot_index,
    input  wire logic [TSZ_W-1:0]     s_tuple_size,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                dp_status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [SLOT_ID_W-1:0]      m_slot_id,
    output logic [OFS_W-1:0]          m_tuple_offset,
    output logic [SIZE_W-1:0]         m_stored_size,
    output logic                      m_relocated
);

    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int EXT_W   = (CNT_W > SLOT_ID_W) ? CNT_W : SLOT_ID_W;
    localparam int AW      = (CNT_W + 6 > 15) ? CNT_W + 6 : 15;
    localparam int ENTRY_W = 1 + OFS_W + SIZE_W;

    // captured item
    mode_t                mode_reg;
    logic [SLOT_ID_W-1:0] idx_reg;
    logic [TSZ_W-1:0]     tsz_reg;

    logic [FP_W-1:0]  fp_reg,  fp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg;
    logic [SLOT_ID_W-1:0] m_slot_id_reg;
    logic [OFS_W-1:0]     m_tuple_offset_reg;
    logic [SIZE_W-1:0]    m_stored_size_reg;
    logic                 m_relocated_reg;

    logic [EXT_W-1:0] s_idx_ext;
    logic [EXT_W-1:0] idx_ext;
    logic [ENTRY_W-1:0] rd_entry;
    logic               rd_del;
    logic [OFS_W-1:0]   rd_off;
    logic [SIZE_W-1:0]  rd_size;

    logic [AW-1:0]     padded;
    logic [AW-1:0]     used;
    logic [AW-1:0]     fp_ext;
    logic [AW-1:0]     gap;
    logic              full;
    logic              ins_ok;
    logic [OFS_W-1:0]  new_off;
    logic [SIZE_W-1:0] new_size;
    logic              idx_bad;
    logic              slot_live;
    logic              upd_fits;
    logic              reloc_needed;

    logic               ins_write;
    logic               del_write;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic                 load;
    status_t              res_status;
    logic [SLOT_ID_W-1:0] res_slot_id;
    logic [OFS_W-1:0]     res_off;
    logic [SIZE_W-1:0]    res_size;
    logic                 res_reloc;

    assign s_idx_ext = EXT_W'(s_slot_index);
    assign idx_ext   = EXT_W'(idx_reg);

    spsm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_SLOTS)
    ) u_slot_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.capture),
        .rd_addr(s_idx_ext[IDX_W-1:0]),
        .rd_data(rd_entry)
    );

    assign rd_del  = rd_entry[ENTRY_W-1];
    assign rd_off  = rd_entry[OFS_W+SIZE_W-1:SIZE_W];
    assign rd_size = rd_entry[SIZE_W-1:0];

    // space check for an append at the end of the slot array
    always_comb begin
        padded   = (AW'(tsz_reg) + AW'(PAD_MASK)) & ~AW'(PAD_MASK);
        used     = AW'(HEADER_BYTES) + AW'(cnt_reg) * AW'(SLOT_BYTES);
        fp_ext   = AW'(fp_reg);
        gap      = (used > fp_ext) ? '0 : fp_ext - used;
        full     = cnt_reg >= CNT_W'(MAX_SLOTS);
        ins_ok   = !full && !(gap < padded + AW'(SLOT_BYTES));
        new_off  = OFS_W'(fp_ext - padded);
        new_size = SIZE_W'(padded);
    end

    assign idx_bad      = idx_ext >= EXT_W'(cnt_reg);
    assign slot_live    = !idx_bad && !rd_del;
    assign upd_fits     = tsz_reg <= rd_size;
    assign reloc_needed = (mode_reg == MODE_UPDATE) && slot_live && !upd_fits;

    assign dp_status.out_free     = !m_valid_reg || m_ready;
    assign dp_status.reloc_needed = reloc_needed;

    assign ins_write = ins_ok &&
                       ((cmd.exec && mode_reg == MODE_INSERT) || cmd.reloc);
    assign del_write = cmd.exec && slot_live &&
                       (mode_reg == MODE_DELETE || reloc_needed);
    assign wr_en     = ins_write || del_write;
    assign wr_addr   = ins_write ? cnt_reg[IDX_W-1:0] : idx_ext[IDX_W-1:0];
    assign wr_data   = ins_write ? {1'b0, new_off, new_size} : {1'b1, rd_off, rd_size};

    assign fp_next  = ins_write ? FP_W'(new_off) : fp_reg;
    assign cnt_next = ins_write ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        res_status  = ST_OK;
        res_slot_id = '0;
        res_off     = '0;
        res_size    = '0;
        res_reloc   = 1'b0;
        if (cmd.reloc) begin
            res_reloc = 1'b1;
            if (ins_ok) begin
                res_slot_id = SLOT_ID_W'(cnt_reg);
                res_off     = new_off;
                res_size    = new_size;
            end else begin
                res_status  = ST_NO_SPACE;
                res_slot_id = idx_reg;
            end
        end else if (mode_reg == MODE_INSERT) begin
            if (ins_ok) begin
                res_slot_id = SLOT_ID_W'(cnt_reg);
                res_off     = new_off;
                res_size    = new_size;
            end else begin
                res_status = ST_NO_SPACE;
            end
        end else begin
            res_slot_id = idx_reg;
            if (idx_bad) begin
                res_status = ST_INVALID_SLOT;
            end else if (rd_del) begin
                res_status = ST_SLOT_DELETED;
            end else begin
                res_off  = rd_off;
                res_size = rd_size;
            end
        end
    end

    assign load         = (cmd.exec && !reloc_needed) || cmd.reloc;
    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg      <= FP_W'(PAGE_BYTES);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fp_reg      <= fp_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= mode_t'(s_mode);
            idx_reg  <= s_slot_index;
            tsz_reg  <= s_tuple_size;
        end
        if (load) begin
            m_status_reg       <= res_status;
            m_slot_id_reg      <= res_slot_id;
            m_tuple_offset_reg <= res_off;
            m_stored_size_reg  <= res_size;
            m_relocated_reg    <= res_reloc;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_id      = m_slot_id_reg;
    assign m_tuple_offset = m_tuple_offset_reg;
    assign m_stored_size  = m_stored_size_reg;
    assign m_relocated    = m_relocated_reg;

    `SPSM_ASSERT_IMP(a_cnt_step, aclk, aresetn, cnt_reg != $past(cnt_reg),
                     (cnt_reg == $past(cnt_reg) + 1'b1) && (fp_reg <= $past(fp_reg)))
    `SPSM_ASSERT_NXT(a_reloc_result, aclk, aresetn, cmd.reloc,
                     m_valid_reg && m_relocated_reg)

endmodule
`default_nettype wire

### rtl/core/slotted_page_slot_manager_core.sv
// Channel | Handshake         | Payload
// --------+-------------------+----------------------------------------------------
// input   | s_valid / s_ready | s_mode, s_slot_index, s_tuple_size
// result  | m_valid / m_ready | m_status, m_slot_id, m_tuple_offset, m_stored_size,
//         |                   | m_relocated
//
// The accept cycle reads the slot table; the execute state then decides and writes
// back. An update that relocates also passes the relocation state, as the single slot
// table write port marks the old slot and then stores the new one.
// Reset is synchronous, active low; the slot table holds no reset state.
// A new item is taken only once the previous one has finished; the block holds
// its finishing cycle while the result register is still occupied.
`default_nettype none
module slotted_page_slot_manager_core
    import spsm_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [MODE_W-1:0]    s_mode,
    input  wire logic [SLOT_ID_W-1:0] s_slot_index,
    input  wire logic [TSZ_W-1:0]     s_tuple_size,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [SLOT_ID_W-1:0]      m_slot_id,
    output logic [OFS_W-1:0]          m_tuple_offset,
    output logic [SIZE_W-1:0]         m_stored_size,
    output logic                      m_relocated
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    spsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .dp_status(dp_status),
        .cmd      (cmd)
    );

    spsm_dp #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_mode        (s_mode),
        .s_slot_index  (s_slot_index),
        .s_tuple_size  (s_tuple_size),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_id     (m_slot_id),
        .m_tuple_offset(m_tuple_offset),
        .m_stored_size (m_stored_size),
        .m_relocated   (m_relocated)
    );

endmodule
`default_nettype wire

### tb/slot_directory_checker.sv
module slot_directory_checker
    import spsm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [MODE_W-1:0]    s_mode,
    input  wire logic [SLOT_ID_W-1:0] s_slot_index,
    input  wire logic [TSZ_W-1:0]     s_tuple_size,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [STATUS_W-1:0]  m_status,
    input  wire logic [SLOT_ID_W-1:0] m_slot_id,
    input  wire logic [OFS_W-1:0]     m_tuple_offset,
    input  wire logic [SIZE_W-1:0]    m_stored_size,
    input  wire logic                 m_relocated,
    output int                        mismatch_count,
    output int                        results_owed
);

    typedef struct packed {
        status_t              status;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [OFS_W-1:0]     tuple_offset;
        logic [SIZE_W-1:0]    stored_size;
        logic                 relocated;
    } slot_result_t;

    int unsigned  heap_top;
    int unsigned  slots_used;
    int unsigned  tuple_ofs [MAX_SLOTS_DEF];
    int unsigned  tuple_len [MAX_SLOTS_DEF];
    bit           tombstone [MAX_SLOTS_DEF];
    slot_result_t owed_results [$];

    // Carve a padded tuple off the heap and append a slot for it.
    function automatic bit alloc_tuple(input int unsigned raw, output int unsigned slot,
                                       output int unsigned ofs, output int unsigned len);
        int unsigned padded;
        int unsigned used;
        int unsigned gap;
        slot = 0;
        ofs = 0;
        len = 0;
        padded = (raw + PAD_MASK) & ~PAD_MASK;
        used = HEADER_BYTES + slots_used * SLOT_BYTES;
        gap = (used > heap_top) ? 0 : heap_top - used;
        if (slots_used >= MAX_SLOTS_DEF || gap < padded + SLOT_BYTES) begin
            return 1'b0;
        end
        heap_top = heap_top - padded;
        tuple_ofs[slots_used] = heap_top;
        tuple_len[slots_used] = padded;
        tombstone[slots_used] = 1'b0;
        slot = slots_used;
        ofs = heap_top;
        len = padded;
        slots_used = slots_used + 1;
        return 1'b1;
    endfunction

    function automatic slot_result_t predict_page_op(input mode_t md, input int unsigned idx,
                                                     input int unsigned tsz);
        slot_result_t r;
        int unsigned  sid;
        int unsigned  ofs;
        int unsigned  len;
        r = '0;
        if (md == MODE_INSERT) begin
            if (alloc_tuple(tsz, sid, ofs, len)) begin
                r.slot_id = SLOT_ID_W'(sid);
                r.tuple_offset = OFS_W'(ofs);
                r.stored_size = SIZE_W'(len);
            end else begin
                r.status = ST_NO_SPACE;
            end
        end else begin
            r.slot_id = SLOT_ID_W'(idx);
            if (idx >= slots_used) begin
                r.status = ST_INVALID_SLOT;
            end else if (tombstone[idx]) begin
                r.status = ST_SLOT_DELETED;
            end else if (md != MODE_UPDATE || tsz <= tuple_len[idx]) begin
                // get, delete and in-place update all report the slot as it stands
                if (md == MODE_DELETE) begin
                    tombstone[idx] = 1'b1;
                end
                r.tuple_offset = OFS_W'(tuple_ofs[idx]);
                r.stored_size = SIZE_W'(tuple_len[idx]);
            end else begin
                // drop the old slot, then reinsert; it stays dropped on failure
                tombstone[idx] = 1'b1;
                r.relocated = 1'b1;
                if (alloc_tuple(tsz, sid, ofs, len)) begin
                    r.slot_id = SLOT_ID_W'(sid);
                    r.tuple_offset = OFS_W'(ofs);
                    r.stored_size = SIZE_W'(len);
                end else begin
                    r.status = ST_NO_SPACE;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        slot_result_t got;
        slot_result_t want;
        if (!aresetn) begin
            heap_top = PAGE_BYTES;
            slots_used = 0;
            owed_results.delete();
        end else begin
            // a result can never belong to an item accepted at the same edge
            if (m_valid && m_ready) begin
                got.status = status_t'(m_status);
                got.slot_id = m_slot_id;
                got.tuple_offset = m_tuple_offset;
                got.stored_size = m_stored_size;
                got.relocated = m_relocated;
                if (owed_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result: status %0d slot %0d offset %0d",
                                 got.status, got.slot_id, got.tuple_offset);
                        $display("  size %0d reloc %0d", got.stored_size, got.relocated);
                    end
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = owed_results.pop_front();
                    if (got.status != want.status || got.slot_id != want.slot_id ||
                        got.tuple_offset != want.tuple_offset ||
                        got.stored_size != want.stored_size ||
                        got.relocated != want.relocated) begin
                        if (mismatch_count < 10) begin
                            $display("result mismatch (expected/actual): status %0d/%0d",
                                     want.status, got.status);
                            $display("  slot %0d/%0d offset %0d/%0d",
                                     want.slot_id, got.slot_id,
                                     want.tuple_offset, got.tuple_offset);
                            $display("  size %0d/%0d reloc %0d/%0d",
                                     want.stored_size, got.stored_size,
                                     want.relocated, got.relocated);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                owed_results.push_back(predict_page_op(mode_t'(s_mode), s_slot_index,
                                                       s_tuple_size));
            end
        end
        results_owed = owed_results.size();
    end

endmodule

### tb/tb_slotted_page_slot_manager_core.sv
module tb_slotted_page_slot_manager_core;
    import spsm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int FILL_ITEMS   = 950;
    localparam int RANDOM_ITEMS = 1450;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic [MODE_W-1:0]    s_mode = '0;
    logic [SLOT_ID_W-1:0] s_slot_index = '0;
    logic [TSZ_W-1:0]     s_tuple_size = '0;
    logic                 m_ready = 1'b0;
    wire logic            s_ready;
    wire logic            m_valid;
    wire logic [STATUS_W-1:0]  m_status;
    wire logic [SLOT_ID_W-1:0] m_slot_id;
    wire logic [OFS_W-1:0]     m_tuple_offset;
    wire logic [SIZE_W-1:0]    m_stored_size;
    wire logic                 m_relocated;

    int mismatch_count;
    int results_owed;
    int src_quiet = 0;
    int sink_quiet = 0;
    int sink_hold = 0;
    int growing_ops = 0;
    int cycles = 0;

    slotted_page_slot_manager_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_slot_index  (s_slot_index),
        .s_tuple_size  (s_tuple_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_id     (m_slot_id),
        .m_tuple_offset(m_tuple_offset),
        .m_stored_size (m_stored_size),
        .m_relocated   (m_relocated)
    );

    slot_directory_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_slot_index  (s_slot_index),
        .s_tuple_size  (s_tuple_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_id     (m_slot_id),
        .m_tuple_offset(m_tuple_offset),
        .m_stored_size (m_stored_size),
        .m_relocated   (m_relocated),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    always #1 aclk = ~aclk;

    // Mostly random waits, with the odd stretch of back-to-back items.
    function automatic int pick_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left = quiet_left - 1;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic mode_t pick_mode(input bit filling);
        int r;
        if (!filling) begin
            return mode_t'($urandom_range(0, 3));
        end
        r = $urandom_range(0, 99);
        if (r < 55) return MODE_INSERT;
        if (r < 70) return MODE_GET;
        if (r < 82) return MODE_DELETE;
        return MODE_UPDATE;
    endfunction

    // Aim mostly at slots that may exist; the item count bounds the slot count.
    function automatic int pick_slot();
        int top;
        top = (growing_ops + 2 > 511) ? 511 : growing_ops + 2;
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(0, top);
        end
        return $urandom_range(0, 511);
    endfunction

    // While filling, keep tuples tiny so the slot limit is reached before the heap runs out.
    function automatic int pick_size(input bit filling, input mode_t md);
        int r;
        r = $urandom_range(0, 99);
        if (md == MODE_UPDATE && r < 50) begin
            return $urandom_range(0, 8);
        end
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 75) return 0;
            if (r < 95) return $urandom_range(1, 16);
            return $urandom_range(4081, 4096);
        end
        if (r < 20) return $urandom_range(0, 16);
        if (r < 60) return $urandom_range(0, 512);
        return $urandom_range(0, 4096);
    endfunction

    task automatic send_op(input mode_t md, input int idx, input int tsz);
        int gap;
        gap = pick_wait(src_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_slot_index <= SLOT_ID_W'(idx);
        s_tuple_size <= TSZ_W'(tsz);
        if (md == MODE_INSERT || md == MODE_UPDATE) begin
            growing_ops = growing_ops + 1;
        end
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin : result_sink
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold <= 0;
        end else if (m_ready && m_valid) begin
            w = pick_wait(sink_quiet);
            m_ready <= (w == 0);
            sink_hold <= w;
        end else if (!m_ready) begin
            if (sink_hold <= 1) begin
                m_ready <= 1'b1;
            end
            sink_hold <= sink_hold - 1;
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles = cycles + 1;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        bit    filling;
        mode_t md;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty page: every slot access is out of range
        send_op(MODE_GET, 0, 0);
        send_op(MODE_DELETE, 511, 0);
        send_op(MODE_UPDATE, 0, 4096);
        // too large for the empty page, at and just past the boundary
        send_op(MODE_INSERT, 0, 4096);
        send_op(MODE_INSERT, 0, 4081);
        send_op(MODE_INSERT, 0, 4095);
        // padding: 0, 1, 7, 8 and 9 bytes
        send_op(MODE_INSERT, 0, 0);
        send_op(MODE_INSERT, 0, 1);
        send_op(MODE_INSERT, 0, 7);
        send_op(MODE_INSERT, 0, 8);
        send_op(MODE_INSERT, 0, 9);
        send_op(MODE_GET, 4, 0);
        send_op(MODE_GET, 5, 0);
        // in-place updates, then one that relocates
        send_op(MODE_UPDATE, 1, 8);
        send_op(MODE_UPDATE, 1, 0);
        send_op(MODE_UPDATE, 0, 0);
        send_op(MODE_UPDATE, 0, 5);
        // every access of a deleted slot
        send_op(MODE_GET, 0, 0);
        send_op(MODE_DELETE, 0, 0);
        send_op(MODE_UPDATE, 0, 0);
        send_op(MODE_DELETE, 2, 0);
        send_op(MODE_GET, 2, 0);
        // relocation that finds no room leaves the old slot deleted
        send_op(MODE_UPDATE, 3, 4096);
        send_op(MODE_GET, 3, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            filling = (n < FILL_ITEMS);
            md = pick_mode(filling);
            send_op(md, pick_slot(), pick_size(filling, md));
        end
        s_valid <= 1'b0;

        do @(negedge aclk); while (results_owed != 0);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
